// ===== src/array_list_insert_remove_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the array list core
// Shared forms for the concurrent checks, clocked on clk, quiet during rst.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_REMOVE_CORE_MACROS_SVH
`define ARRAY_LIST_INSERT_REMOVE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALR_ASSERT_IMPL(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALR_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== src/alr_pkg.sv =====
// ---------------------------------------------------------------------------
// Array list package
// Sizes, operation and status codes, and the control bundle for the cells.
// ---------------------------------------------------------------------------
package alr_pkg;

  // List size and field widths.
  localparam int CAPACITY = 8;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 4;
  localparam int VALUE_W  = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // Operation codes carried by the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_EDIT   = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_t;

  // What every cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_COMPACT
  } cell_op_t;

  // Controller state.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REMOVE,
    S_DUMP
  } state_t;

  // Broadcast control for the row of cells.
  typedef struct packed {
    cell_op_t                   op;
    logic [INDEX_W-1:0]         index;
    logic signed [VALUE_W-1:0]  value;
    logic [COUNT_W-1:0]         count;
  } cell_ctl_t;

endpackage

// ===== src/alr_in_if.sv =====
// ---------------------------------------------------------------------------
// Array list command channel
// Valid/ready channel carrying one list operation per transfer.
// ---------------------------------------------------------------------------
interface alr_in_if;
  logic                               valid;
  logic                               ready;
  logic [alr_pkg::MODE_W-1:0]         mode;
  logic signed [alr_pkg::VALUE_W-1:0] value;
  logic [alr_pkg::INDEX_W-1:0]        index;

  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface

// ===== src/alr_out_if.sv =====
// ---------------------------------------------------------------------------
// Array list result channel
// Valid/ready channel carrying one result per transfer.
// ---------------------------------------------------------------------------
interface alr_out_if;
  logic                               valid;
  logic                               ready;
  logic [alr_pkg::STATUS_W-1:0]       status;
  logic [alr_pkg::COUNT_W-1:0]        count;
  logic                               is_empty;
  logic                               is_full;
  logic [alr_pkg::COUNT_W-1:0]        removed;
  logic signed [alr_pkg::VALUE_W-1:0] entry_value;
  logic [alr_pkg::INDEX_W-1:0]        entry_position;
  logic                               last;

  modport source (output valid, status, count, is_empty, is_full, removed,
                  entry_value, entry_position, last, input ready);
  modport sink   (input valid, status, count, is_empty, is_full, removed,
                  entry_value, entry_position, last, output ready);
endinterface

// ===== src/alr_cell.sv =====
// ---------------------------------------------------------------------------
// Array list cell
// Holds one list entry and moves it to or from its neighbours on command.
// ---------------------------------------------------------------------------
module alr_cell (
  input  logic                               clk,
  input  alr_pkg::cell_ctl_t                 ctl,
  input  logic [alr_pkg::INDEX_W-1:0]        pos,
  input  logic signed [alr_pkg::VALUE_W-1:0] prev_value,
  input  logic signed [alr_pkg::VALUE_W-1:0] next_value,
  input  logic                               kill_below,
  output logic                               kill_above,
  output logic signed [alr_pkg::VALUE_W-1:0] value
);

  logic match;

  // A live entry equal to the search value; everything from the first such
  // entry onwards moves down one place in a compaction step.
  assign match      = (ctl.op == alr_pkg::CELL_COMPACT) && (value == ctl.value) &&
                      ({1'b0, pos} < ctl.count);
  assign kill_above = kill_below | match;

  // Entry register.
  always_ff @(posedge clk) begin
    case (ctl.op)
      alr_pkg::CELL_WRITE: begin
        if (pos == ctl.index) value <= ctl.value;
      end
      alr_pkg::CELL_INSERT: begin
        if (pos == ctl.index) value <= ctl.value;
        else if (pos > ctl.index) value <= prev_value;
      end
      alr_pkg::CELL_COMPACT: begin
        if (kill_above) value <= next_value;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/array_list_insert_remove_core.sv =====
// ---------------------------------------------------------------------------
// Array list insert/remove core
// Bounded ordered list held in a row of cells, with a small sequencer.
// ---------------------------------------------------------------------------
// Usage: commands arrive on cmd (mode, value, index) and results leave on
// result. Every command gives one result, except a dump of a non-empty list,
// which gives one result per stored entry in order, the final one with last
// set. Each result carries the status, the count after the command and the
// empty and full flags.
// Sequence: a command is taken in S_IDLE and executed in S_EXEC, S_REMOVE or
// S_DUMP. A remove drops one matching entry per cycle from the cell row until
// none is left, then gives its result. A dump of a non-empty list gives one
// entry per cycle while the receiver takes them, through the single read port
// of the row. Each result is presented from the edge that ends the cycle that
// produced it.
// The result register lets the next command be taken while a result waits.
// When the receiver stalls the sequencer holds its result step until the result
// register frees up. Reset empties the list; entry contents are not cleared,
// as positions at or past the count are never read.
// ---------------------------------------------------------------------------
`include "array_list_insert_remove_core_macros.svh"

module array_list_insert_remove_core (
  input  logic       clk,
  input  logic       rst,
  alr_in_if.sink     cmd,
  alr_out_if.source  result
);

  localparam int CAP = alr_pkg::CAPACITY;
  localparam logic [alr_pkg::COUNT_W-1:0] CAP_COUNT = alr_pkg::COUNT_W'(CAP);

  alr_pkg::state_t state, state_next;

  logic [alr_pkg::COUNT_W-1:0]        count, count_next;
  logic [alr_pkg::COUNT_W-1:0]        removed, removed_next;
  logic [alr_pkg::INDEX_W-1:0]        dump_ptr, dump_ptr_next;
  logic [alr_pkg::COUNT_W-1:0]        dump_ptr_ext;
  logic [alr_pkg::MODE_W-1:0]         cmd_mode;
  logic signed [alr_pkg::VALUE_W-1:0] cmd_value;
  logic [alr_pkg::INDEX_W-1:0]        cmd_index;
  alr_pkg::status_t                   cmd_status, accept_status;

  alr_pkg::cell_ctl_t                 cell_ctl;
  logic signed [alr_pkg::VALUE_W-1:0] cell_value [CAP];
  logic [CAP:0]                       kill;
  logic                               any_match;

  logic                               in_accept;
  logic                               slot_free;
  logic                               push;
  alr_pkg::status_t                   push_status;
  logic [alr_pkg::COUNT_W-1:0]        push_removed;
  logic signed [alr_pkg::VALUE_W-1:0] push_value;
  logic [alr_pkg::INDEX_W-1:0]        push_pos;
  logic                               push_last;

  logic                               out_valid;
  alr_pkg::status_t                   out_status;
  logic [alr_pkg::COUNT_W-1:0]        out_count;
  logic                               out_is_empty;
  logic                               out_is_full;
  logic [alr_pkg::COUNT_W-1:0]        out_removed;
  logic signed [alr_pkg::VALUE_W-1:0] out_entry_value;
  logic [alr_pkg::INDEX_W-1:0]        out_entry_position;
  logic                               out_last;

  logic                               remove_step;
  logic                               dump_done;

  // Row of cells; each sees its neighbours and the first-match flag ripples up.
  assign kill[0] = 1'b0;
  generate
    for (genvar i = 0; i < CAP; i++) begin : g_cell
      alr_cell u_cell (
        .clk        (clk),
        .ctl        (cell_ctl),
        .pos        (alr_pkg::INDEX_W'(i)),
        .prev_value ((i == 0) ? cmd_value : cell_value[(i == 0) ? 0 : i - 1]),
        .next_value ((i == CAP - 1) ? cell_value[i]
                                     : cell_value[(i == CAP - 1) ? i : i + 1]),
        .kill_below (kill[i]),
        .kill_above (kill[i+1]),
        .value      (cell_value[i])
      );
    end
  endgenerate
  assign any_match = kill[CAP];

  assign in_accept    = cmd.valid && cmd.ready;
  assign cmd.ready    = (state == alr_pkg::S_IDLE);
  assign slot_free    = !out_valid || result.ready;
  assign dump_ptr_ext = {1'b0, dump_ptr};

  // Status of an incoming command against the current count.
  always_comb begin
    accept_status = alr_pkg::STATUS_OK;
    case (cmd.mode)
      alr_pkg::MODE_APPEND: begin
        if (count >= CAP_COUNT) accept_status = alr_pkg::STATUS_FULL;
      end
      alr_pkg::MODE_INSERT: begin
        if (count >= CAP_COUNT) accept_status = alr_pkg::STATUS_FULL;
        else if (count == '0) accept_status = alr_pkg::STATUS_EMPTY;
        else if ({1'b0, cmd.index} >= count) accept_status = alr_pkg::STATUS_BAD_INDEX;
      end
      alr_pkg::MODE_REMOVE, alr_pkg::MODE_DUMP: begin
        if (count == '0) accept_status = alr_pkg::STATUS_EMPTY;
      end
      alr_pkg::MODE_EDIT: begin
        if (count == '0) accept_status = alr_pkg::STATUS_EMPTY;
        else if ({1'b0, cmd.index} >= count) accept_status = alr_pkg::STATUS_BAD_INDEX;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: next state, cell commands and result generation.
  always_comb begin
    state_next     = state;
    count_next     = count;
    removed_next   = removed;
    dump_ptr_next  = dump_ptr;
    cell_ctl.op    = alr_pkg::CELL_HOLD;
    cell_ctl.index = cmd_index;
    cell_ctl.value = cmd_value;
    cell_ctl.count = count;
    push           = 1'b0;
    push_status    = cmd_status;
    push_removed   = '0;
    push_value     = '0;
    push_pos       = '0;
    push_last      = 1'b1;
    case (state)
      alr_pkg::S_IDLE: begin
        if (in_accept) begin
          removed_next  = '0;
          dump_ptr_next = '0;
          if (cmd.mode == alr_pkg::MODE_REMOVE) state_next = alr_pkg::S_REMOVE;
          else if (cmd.mode == alr_pkg::MODE_DUMP && count != '0)
            state_next = alr_pkg::S_DUMP;
          else state_next = alr_pkg::S_EXEC;
        end
      end
      alr_pkg::S_EXEC: begin
        if (slot_free) begin
          push       = 1'b1;
          state_next = alr_pkg::S_IDLE;
          if (cmd_status == alr_pkg::STATUS_OK) begin
            case (cmd_mode)
              alr_pkg::MODE_APPEND: begin
                cell_ctl.op    = alr_pkg::CELL_WRITE;
                cell_ctl.index = count[alr_pkg::INDEX_W-1:0];
                count_next     = count + 1'b1;
              end
              alr_pkg::MODE_INSERT: begin
                cell_ctl.op = alr_pkg::CELL_INSERT;
                count_next  = count + 1'b1;
              end
              alr_pkg::MODE_EDIT: begin
                cell_ctl.op = alr_pkg::CELL_WRITE;
              end
              default: begin
              end
            endcase
          end
        end
      end
      alr_pkg::S_REMOVE: begin
        // One matching entry leaves the row per cycle until none is left.
        cell_ctl.op = alr_pkg::CELL_COMPACT;
        if (any_match) begin
          count_next   = count - 1'b1;
          removed_next = removed + 1'b1;
        end else if (slot_free) begin
          push         = 1'b1;
          push_removed = removed;
          state_next   = alr_pkg::S_IDLE;
        end
      end
      alr_pkg::S_DUMP: begin
        if (slot_free) begin
          push          = 1'b1;
          push_value    = cell_value[dump_ptr];
          push_pos      = dump_ptr;
          push_last     = (dump_ptr_ext + 1'b1 == count);
          dump_ptr_next = dump_ptr + 1'b1;
          if (push_last) state_next = alr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = alr_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alr_pkg::S_IDLE;
      count     <= '0;
      removed   <= '0;
      dump_ptr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      removed  <= removed_next;
      dump_ptr <= dump_ptr_next;
      if (push) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_mode   <= cmd.mode;
      cmd_value  <= cmd.value;
      cmd_index  <= cmd.index;
      cmd_status <= accept_status;
    end
    if (push) begin
      out_status         <= push_status;
      out_count          <= count_next;
      out_is_empty       <= (count_next == '0);
      out_is_full        <= (count_next == CAP_COUNT);
      out_removed        <= push_removed;
      out_entry_value    <= push_value;
      out_entry_position <= push_pos;
      out_last           <= push_last;
    end
  end

  // Result channel.
  assign result.valid          = out_valid;
  assign result.status         = out_status;
  assign result.count          = out_count;
  assign result.is_empty       = out_is_empty;
  assign result.is_full        = out_is_full;
  assign result.removed        = out_removed;
  assign result.entry_value    = out_entry_value;
  assign result.entry_position = out_entry_position;
  assign result.last           = out_last;

  // Conditions watched by the checks below.
  assign remove_step = (state == alr_pkg::S_REMOVE) && any_match;
  assign dump_done   = (state == alr_pkg::S_DUMP) && push && push_last;

  // Checks on the sequencer.
  `ALR_ASSERT_IMPL(a_count_bound, 1'b1, count <= CAP_COUNT, "count above capacity")
  `ALR_ASSERT_NEXT(a_rm_count, remove_step, count == $past(count) - 1'b1, "count not cut")
  `ALR_ASSERT_NEXT(a_rm_tally, remove_step, removed == $past(removed) + 1'b1, "tally stuck")
  `ALR_ASSERT_IMPL(a_dump_ptr, state == alr_pkg::S_DUMP, dump_ptr_ext < count, "dump past end")
  `ALR_ASSERT_NEXT(a_dump_end, dump_done, state == alr_pkg::S_IDLE, "dump did not finish")

endmodule

// ===== tb/array_list_insert_remove_core_tb.sv =====
// ---------------------------------------------------------------------------
// Array list insert/remove core testbench
// Drives list commands through the command channel and predicts every result
// with a shadow copy of the list. Each result transfer is checked field by
// field against the oldest prediction. Directed commands cover the corner
// cases, then random traffic runs with random gaps on both sides, a long
// receiver hold-off and a sender pause until the result stream drains.
// ---------------------------------------------------------------------------
module array_list_insert_remove_core_tb;
  import alr_pkg::*;

  // Run limits and stimulus sizes.
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE_TICKS = 20;
  localparam int MAX_DUMP     = 8;
  localparam int RANDOM_ITEMS = 200;
  localparam int STRETCH_LEN  = 40;
  localparam int HOLD_TICKS   = 100;

  // Mode codes that the block does not use.
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

  // Extreme entry values.
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;
    logic                       is_empty;
    logic                       is_full;
    logic [COUNT_W-1:0]         removed;
    logic signed [VALUE_W-1:0]  entry_value;
    logic [INDEX_W-1:0]         entry_position;
    logic                       last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;

  alr_in_if  in_ch ();
  alr_out_if out_ch ();

  array_list_insert_remove_core dut (
    .clk    (clk),
    .rst    (rst),
    .cmd    (in_ch),
    .result (out_ch)
  );

  // Shadow copy of the list and the results still owed by the block.
  logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
  int                        shadow_count;
  list_result_t              results_due [$];

  int errors       = 0;
  int cycle_count  = 0;
  bit idle_en      = 1'b1;
  int stall_left   = 0;
  int receiver_hold = 0;
  logic signed [VALUE_W-1:0] value_pool [4];

  // Clock generation.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Queue one predicted result, taking the count and flags from the shadow list.
  function automatic void push_result(logic [STATUS_W-1:0] st, int dropped,
                                      logic signed [VALUE_W-1:0] v, int pos,
                                      logic fin);
    list_result_t r;
    r.status         = st;
    r.count          = COUNT_W'(shadow_count);
    r.is_empty       = (shadow_count == 0);
    r.is_full        = (shadow_count == CAPACITY);
    r.removed        = COUNT_W'(dropped);
    r.entry_value    = v;
    r.entry_position = INDEX_W'(pos);
    r.last           = fin;
    results_due.push_back(r);
  endfunction

  // Apply one accepted command to the shadow list and predict its results.
  function automatic void apply_list_op(logic [MODE_W-1:0] op,
                                        logic signed [VALUE_W-1:0] v,
                                        logic [INDEX_W-1:0] ix);
    logic [STATUS_W-1:0] st;
    int dropped;
    int kept;
    int n;
    st      = STATUS_OK;
    dropped = 0;
    case (op)
      MODE_APPEND: begin
        if (shadow_count >= CAPACITY) begin
          st = STATUS_FULL;
        end else begin
          shadow_entries[shadow_count] = v;
          shadow_count++;
        end
      end
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          st = STATUS_FULL;
        end else if (shadow_count == 0) begin
          st = STATUS_EMPTY;
        end else if (int'(ix) >= shadow_count) begin
          st = STATUS_BAD_INDEX;
        end else begin
          for (int i = shadow_count; i > int'(ix); i--) begin
            shadow_entries[i] = shadow_entries[i-1];
          end
          shadow_entries[ix] = v;
          shadow_count++;
        end
      end
      MODE_REMOVE: begin
        if (shadow_count == 0) begin
          st = STATUS_EMPTY;
        end else begin
          // Keep the survivors in order; every match goes, adjacent ones too.
          kept = 0;
          for (int i = 0; i < shadow_count; i++) begin
            if (shadow_entries[i] != v) begin
              shadow_entries[kept] = shadow_entries[i];
              kept++;
            end
          end
          dropped      = shadow_count - kept;
          shadow_count = kept;
        end
      end
      MODE_EDIT: begin
        if (shadow_count == 0) begin
          st = STATUS_EMPTY;
        end else if (int'(ix) >= shadow_count) begin
          st = STATUS_BAD_INDEX;
        end else begin
          shadow_entries[ix] = v;
        end
      end
      MODE_DUMP: begin
        if (shadow_count == 0) begin
          push_result(STATUS_EMPTY, 0, '0, 0, 1'b1);
        end else begin
          n = (shadow_count > MAX_DUMP) ? MAX_DUMP : shadow_count;
          for (int i = 0; i < n; i++) begin
            push_result(STATUS_OK, 0, shadow_entries[i], i, i == n - 1);
          end
        end
        return;
      end
      default: ;
    endcase
    push_result(st, dropped, '0, 0, 1'b1);
  endfunction

  // Send one command: optional gap, then hold valid until the transfer.
  task automatic send_cmd(logic [MODE_W-1:0] op, logic signed [VALUE_W-1:0] v,
                          logic [INDEX_W-1:0] ix);
    int gap;
    gap = idle_en ? $urandom_range(4, 0) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.mode  = op;
    in_ch.value = v;
    in_ch.index = ix;
    do @(posedge clk); while (!in_ch.ready);
    apply_list_op(op, v, ix);
  endtask

  // Stop offering commands and wait until every predicted result has arrived.
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // One random command, mostly well-formed, with values often repeated.
  task automatic send_random_item();
    int r;
    logic [MODE_W-1:0] op;
    logic signed [VALUE_W-1:0] v;
    logic [INDEX_W-1:0] ix;
    r = $urandom_range(99, 0);
    if (r < 28 || (shadow_count < 2 && r < 45)) op = MODE_APPEND;
    else if (r < 48) op = MODE_INSERT;
    else if (r < 62) op = MODE_REMOVE;
    else if (r < 77) op = MODE_EDIT;
    else if (r < 93) op = MODE_DUMP;
    else op = MODE_W'($urandom_range(MODE_SPARE_LAST, MODE_SPARE_FIRST));
    v = ($urandom_range(1, 0) != 0) ? value_pool[2'($urandom_range(3, 0))] : $urandom;
    if (shadow_count > 0 && $urandom_range(3, 0) != 0) begin
      ix = INDEX_W'($urandom_range(shadow_count - 1, 0));
    end else begin
      ix = INDEX_W'($urandom_range(CAPACITY - 1, 0));
    end
    send_cmd(op, v, ix);
  endtask

  // Receiver ready: long hold-off first, then the per-result stall.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ch.ready = 1'b0;
      end else if (receiver_hold > 0) begin
        out_ch.ready = 1'b0;
        receiver_hold--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare a single field and report it on mismatch.
  function automatic void check_field(string name, logic [VALUE_W-1:0] exp_v,
                                      logic [VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      stall_left = idle_en ? $urandom_range(4, 0) : 0;
      if (results_due.size() == 0) begin
        $error("result transfer with no prediction waiting");
        errors++;
      end else begin
        want = results_due.pop_front();
        check_field("status", want.status, out_ch.status);
        check_field("count", want.count, out_ch.count);
        check_field("is_empty", want.is_empty, out_ch.is_empty);
        check_field("is_full", want.is_full, out_ch.is_full);
        check_field("removed", want.removed, out_ch.removed);
        check_field("entry_value", want.entry_value, out_ch.entry_value);
        check_field("entry_position", want.entry_position, out_ch.entry_position);
        check_field("last", want.last, out_ch.last);
      end
    end
  end

  // Corner cases: empty list, bad indices, full list, duplicates, spare modes.
  task automatic test_directed();
    send_cmd(MODE_DUMP, '0, '0);
    send_cmd(MODE_REMOVE, VAL_MAX, '0);
    send_cmd(MODE_INSERT, 32'sd1, '0);
    send_cmd(MODE_EDIT, 32'sd2, '0);
    send_cmd(MODE_SPARE_FIRST, VAL_MIN, 3'd7);
    send_cmd(MODE_APPEND, VAL_MIN, '0);
    send_cmd(MODE_APPEND, VAL_MAX, 3'd7);
    // Insert only goes before an existing entry, so index == count is refused.
    send_cmd(MODE_INSERT, 32'sd5, 3'd2);
    send_cmd(MODE_INSERT, -32'sd1, '0);
    send_cmd(MODE_INSERT, 32'sd42, 3'd2);
    send_cmd(MODE_EDIT, '0, 3'd3);
    send_cmd(MODE_EDIT, 32'sd9, 3'd4);
    send_cmd(MODE_APPEND, 32'sd42, '0);
    send_cmd(MODE_APPEND, 32'sd42, '0);
    send_cmd(MODE_APPEND, -32'sd1, 3'd5);
    send_cmd(MODE_APPEND, VAL_MAX, 3'd6);
    // The list is full now.
    send_cmd(MODE_APPEND, 32'sd1, '0);
    send_cmd(MODE_INSERT, 32'sd1, '0);
    send_cmd(MODE_EDIT, VAL_MIN, 3'd7);
    send_cmd(MODE_DUMP, '0, '0);
    // Three matches, two of them adjacent, then a remove with no match.
    send_cmd(MODE_REMOVE, 32'sd42, '0);
    send_cmd(MODE_REMOVE, 32'sd12345, '0);
    send_cmd(MODE_EDIT, 32'sd1, 3'd7);
    send_cmd(MODE_SPARE_LAST, -32'sd1, 3'd7);
    send_cmd(MODE_DUMP, '0, 3'd7);
  endtask

  // Random traffic with alternating stretches of idling and none.
  task automatic test_random();
    value_pool[0] = VAL_MIN;
    value_pool[1] = VAL_MAX;
    value_pool[2] = $urandom;
    value_pool[3] = $urandom;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      idle_en = ((k / STRETCH_LEN) % 2) == 0;
      send_random_item();
    end
    idle_en = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, so the block stalls.
  task automatic test_backpressure();
    wait_for_results();
    idle_en       = 1'b0;
    receiver_hold = HOLD_TICKS;
    for (int k = 0; k < 16; k++) begin
      if (k % 2 == 0) send_cmd(MODE_APPEND, $urandom, INDEX_W'($urandom));
      else send_cmd(MODE_DUMP, $urandom, INDEX_W'($urandom));
    end
    idle_en = 1'b1;
  endtask

  // The sender pauses until the result stream has fully drained.
  task automatic test_drain_pause();
    for (int k = 0; k < 8; k++) send_random_item();
    wait_for_results();
    for (int k = 0; k < 8; k++) send_random_item();
  endtask

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.mode   = '0;
    in_ch.value  = '0;
    in_ch.index  = '0;
    shadow_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random();
    test_backpressure();
    test_drain_pause();

    wait_for_results();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
